FILE: sv/edd_pkg.sv
// ----------------------------------------------------------------------------
// edd_pkg: shared types and constants of the error diffusion ditherer
// Field widths, register indexes, diffusion weights and the share function.
// ----------------------------------------------------------------------------
package edd_pkg;

  localparam int PixelBits   = 8;
  localparam int WidthBits   = 12;
  localparam int HeightBits  = 16;
  localparam int AddrBits    = 3;
  localparam int DataBits    = 32;
  localparam int OutDepth    = 3;

  // Register indexes, taken from paddr[2].
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  localparam logic [WidthBits-1:0]  WidthReset  = 12'd512;
  localparam logic [HeightBits-1:0] HeightReset = 16'd512;

  // Diffusion weights in sixteenths.
  localparam logic [2:0] WeightRight     = 3'd7;
  localparam logic [2:0] WeightBelowLeft = 3'd3;
  localparam logic [2:0] WeightBelow     = 3'd5;
  localparam logic [2:0] WeightBelowRight = 3'd1;

  localparam logic [PixelBits:0] WhiteLevel = 9'd255;

  typedef struct packed {
    logic end_of_frame;
    logic end_of_row;
    logic level;
  } out_t;

  // Share of the error: err * weight / 16, truncated toward zero, modulo 256.
  function automatic logic [7:0] edd_share(input logic signed [8:0] err,
                                           input logic [2:0] weight);
    logic signed [11:0] prod;
    logic signed [11:0] biased;
    prod   = 12'(err) * $signed({9'b0, weight});
    biased = prod[11] ? prod + 12'sd15 : prod;
    return biased[11:4];
  endfunction

endpackage

FILE: sv/edd_ram.sv
// ----------------------------------------------------------------------------
// edd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

FILE: sv/edd_core.sv
// ----------------------------------------------------------------------------
// edd_core: position tracking, row error store and error diffusion
// Stage 0 counts the raster position and reads the error left by the row
// above; stage 1 quantizes, splits the error and writes the store back.
// ----------------------------------------------------------------------------
module edd_core import edd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [PixelBits-1:0]  pixel_i,
  input  logic [WidthBits-1:0]  width_i,
  input  logic [HeightBits-1:0] height_i,
  output logic                  res_valid_o,
  output out_t                  res_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > WidthBits) ? CW + 1 : WidthBits;

  // Stage 0: raster position.
  logic [CW-1:0]         column_q, column_d;
  logic [HeightBits-1:0] row_q, row_d;
  logic [WW-1:0]         w_ext, w_eff, col_ext, last_col, col_sel;
  logic [HeightBits-1:0] h_eff;
  logic [CW-1:0]         col;
  logic                  eor, eof;

  always_comb begin
    w_ext = WW'(width_i);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    last_col = w_eff - WW'(1);
    col_ext  = WW'(column_q);
    col_sel  = (col_ext >= w_eff) ? last_col : col_ext;
    col      = col_sel[CW-1:0];
    eor      = (col_sel == last_col);
    h_eff    = (height_i == '0) ? HeightBits'(1) : height_i;
    eof      = eor && (({1'b0, row_q} + 17'd1) >= {1'b0, h_eff});

    column_d = column_q;
    row_d    = row_q;
    if (accept_i) begin
      if (eor) begin
        column_d = '0;
        row_d    = eof ? '0 : row_q + HeightBits'(1);
      end else begin
        column_d = col + CW'(1);
      end
    end
  end

  // Stage 1 registers.
  logic                 s1_valid_q;
  logic [PixelBits-1:0] s1_pixel_q;
  logic [CW-1:0]        s1_col_q;
  logic                 s1_eor_q, s1_eof_q, s1_above_q;
  logic                 fwd_hit_q;
  logic [7:0]           fwd_data_q;

  // Diffusion state.
  logic [7:0] right_q, right_d;
  logic [7:0] bl_q, bl_d;
  logic [7:0] bp_q, bp_d;

  // Write port and the deferred end-of-row write.
  logic          wr_en, direct_en, new_pend;
  logic [CW-1:0] wr_addr, direct_addr;
  logic [7:0]    wr_data, direct_data;
  logic          pend_valid_q, pend_valid_d;
  logic [CW-1:0] pend_addr_q;
  logic [7:0]    pend_data_q;

  logic [7:0]        rd_data, above, work;
  logic              white;
  logic signed [8:0] err;
  logic [7:0]        s_right, s_bl, s_below, s_br, bl_new;

  edd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (accept_i),
    .rd_addr_i(col),
    .rd_data_o(rd_data)
  );

  always_comb begin
    if (!s1_above_q) begin
      above = '0;
    end else begin
      above = fwd_hit_q ? fwd_data_q : rd_data;
    end
    work    = s1_pixel_q + above + right_q;
    white   = work[7];
    err     = $signed({1'b0, work}) - $signed(white ? WhiteLevel : 9'd0);
    s_right = edd_share(err, WeightRight);
    s_bl    = edd_share(err, WeightBelowLeft);
    s_below = edd_share(err, WeightBelow);
    s_br    = edd_share(err, WeightBelowRight);
    bl_new  = bp_q + s_below;

    right_d = right_q;
    bl_d    = bl_q;
    bp_d    = bp_q;
    if (s1_valid_q) begin
      if (s1_eor_q) begin
        right_d = '0;
        bl_d    = '0;
        bp_d    = '0;
      end else begin
        right_d = s_right;
        bl_d    = bl_new;
        bp_d    = s_br;
      end
    end

    // A row end past column zero needs two writes; the second one is held until
    // the port is free, as when the next pixel sits at column zero.
    direct_en   = 1'b0;
    direct_addr = s1_col_q;
    direct_data = bl_new;
    new_pend    = 1'b0;
    if (s1_valid_q) begin
      if (s1_col_q != '0) begin
        direct_en   = 1'b1;
        direct_addr = s1_col_q - CW'(1);
        direct_data = bl_q + s_bl;
        new_pend    = s1_eor_q;
      end else if (s1_eor_q) begin
        direct_en   = 1'b1;
      end
    end
    wr_en        = direct_en || pend_valid_q;
    wr_addr      = direct_en ? direct_addr : pend_addr_q;
    wr_data      = direct_en ? direct_data : pend_data_q;
    pend_valid_d = new_pend || (pend_valid_q && direct_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q     <= '0;
      row_q        <= '0;
      s1_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      right_q      <= '0;
      bl_q         <= '0;
      bp_q         <= '0;
    end else begin
      column_q     <= column_d;
      row_q        <= row_d;
      s1_valid_q   <= accept_i;
      pend_valid_q <= pend_valid_d;
      right_q      <= right_d;
      bl_q         <= bl_d;
      bp_q         <= bp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pixel_q <= pixel_i;
      s1_col_q   <= col;
      s1_eor_q   <= eor;
      s1_eof_q   <= eof;
      s1_above_q <= (row_q != '0);
      // A write landing on the entry being read overrides the RAM output.
      fwd_hit_q  <= wr_en && (wr_addr == col);
      fwd_data_q <= wr_data;
    end
    if (new_pend) begin
      pend_addr_q <= s1_col_q;
      pend_data_q <= bl_new;
    end
  end

  assign res_valid_o        = s1_valid_q;
  assign res_o.level        = white;
  assign res_o.end_of_row   = s1_eor_q;
  assign res_o.end_of_frame = s1_eof_q;

endmodule

FILE: sv/edd_out_buf.sv
// ----------------------------------------------------------------------------
// edd_out_buf: three-entry output queue
// Decouples the result stream from the pipeline so input keeps flowing.
// ----------------------------------------------------------------------------
module edd_out_buf import edd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_t       data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output out_t       data_o,
  output logic [1:0] count_o
);

  out_t       buf_q [OutDepth];
  logic [1:0] wr_ptr_q, rd_ptr_q, cnt_q;

  function automatic logic [1:0] next_ptr(input logic [1:0] ptr);
    return (ptr == 2'(OutDepth - 1)) ? 2'd0 : ptr + 2'd1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign count_o = cnt_q;

endmodule

FILE: sv/error_diffusion_dither_1bit.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_1bit: one-bit Floyd-Steinberg ditherer
// Turns a raster stream of 8-bit gray pixels into black/white pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// result word per pixel through the stage 1 registers and the output queue;
// the rate is set by the registered feedback of the right-hand error share
// and by the single write port of the row error RAM (MAX_WIDTH entries),
// whose second write at each row end is deferred until the port is free.
// The working value wraps modulo 256 and no clearing pass is run after
// reset. Width and height may be written only while no pixel is in flight.
module error_diffusion_dither_1bit import edd_pkg::*; #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [7:0] pixel
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [7:0]           m_axis_tdata_o,   // [0] level, [7:1] zero
  output logic                 m_axis_tlast_o,   // end_of_row
  output logic                 m_axis_tuser_o,   // [0] end_of_frame
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [AddrBits-1:0]  paddr_i,
  input  logic [DataBits-1:0]  pwdata_i,
  output logic [DataBits-1:0]  prdata_o,
  output logic                 pready_o
);

  logic [WidthBits-1:0]  width_q;
  logic [HeightBits-1:0] height_q;
  logic                  cfg_wr, accept, res_valid, s1_busy;
  logic [1:0]            out_cnt;
  out_t                  res, out_word;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_wr) begin
      case (paddr_i[2])
        RegWidth:  width_q  <= pwdata_i[WidthBits-1:0];
        RegHeight: height_q <= pwdata_i[HeightBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr_i[2])
      RegWidth:  prdata_o = DataBits'(width_q);
      RegHeight: prdata_o = DataBits'(height_q);
      default:   prdata_o = '0;
    endcase
  end

  // Queue slots taken plus the word in flight must leave room for one more.
  assign s1_busy         = res_valid;
  assign s_axis_tready_o = ({1'b0, out_cnt} + {2'b0, s1_busy}) <= 3'(OutDepth - 1);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  edd_core #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pixel_i    (s_axis_tdata_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  edd_out_buf u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i (res),
    .pop_i  (m_axis_tvalid_o && m_axis_tready_i),
    .valid_o(m_axis_tvalid_o),
    .data_o (out_word),
    .count_o(out_cnt)
  );

  assign m_axis_tdata_o = {7'b0, out_word.level};
  assign m_axis_tlast_o = out_word.end_of_row;
  assign m_axis_tuser_o = out_word.end_of_frame;

endmodule

FILE: sv/edd_checker.sv
// ----------------------------------------------------------------------------
// edd_checker: port-level checks of the ditherer
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module edd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  // A stalled output word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("output word changed while stalled");

  // The last pixel of a frame is always the last pixel of a row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("end of frame without end of row");

  // Input is held back only while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no result pending");

  // Once an accepted pixel has passed stage 1 into the queue, the output is valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> ##2 m_axis_tvalid_o)
    else $error("accepted pixel produced no result");

endmodule

bind error_diffusion_dither_1bit edd_checker u_edd_checker (.*);

FILE: verif/error_diffusion_dither_1bit_tb.sv
// ----------------------------------------------------------------------------
// error_diffusion_dither_1bit_tb: self-checking bench for the 1-bit ditherer
// Streams gray frames through the block under changing image sizes and
// bursty flow control on both sides. Every output word is checked against
// a cycle-free model of the diffusion that runs as each pixel is accepted.
// ----------------------------------------------------------------------------
module error_diffusion_dither_1bit_tb;
  import edd_pkg::*;

  localparam int MaxWidth     = 2048;
  localparam int CycleLimit   = 400000;
  localparam int RandomPixels = 690;
  localparam int WidePixels   = 96;
  localparam int DrainCycles  = 4;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [AddrBits-1:0]   paddr   = '0;
  logic [DataBits-1:0]   pwdata  = '0;
  logic [DataBits-1:0]   prdata;
  logic                  pready;

  error_diffusion_dither_1bit #(.MAX_WIDTH(MaxWidth)) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),   // [7:0] pixel
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),   // [0] level, [7:1] zero
    .m_axis_tlast_o  (m_axis_tlast),   // end_of_row
    .m_axis_tuser_o  (m_axis_tuser),   // [0] end_of_frame
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Diffusion model state, mirrored from the block.
  logic [WidthBits-1:0]  cfg_width  = WidthReset;
  logic [HeightBits-1:0] cfg_height = HeightReset;
  int                    pos_col    = 0;
  int                    pos_row    = 0;
  logic [7:0]            right_share    = '0;
  logic [7:0]            below_left_sum = '0;
  logic [7:0]            below_sum      = '0;
  logic [7:0]            row_errors [MaxWidth];
  // Entries below this column have been written since reset.
  int                    written_span = 0;

  out_t expected_px [$];

  int  pixels_sent     = 0;
  int  results_checked = 0;
  int  frames_done     = 0;
  int  reg_writes      = 0;
  int  mismatch_count  = 0;
  int  cycle_count     = 0;
  int  burst_left      = 0;
  bit  steady          = 1'b0;
  int  hold_left       = 0;
  int  stall_mode      = 0;
  int  mode_left       = 0;
  int  period_phase    = 0;

  function automatic int active_width(input logic [WidthBits-1:0] raw);
    if (raw == 0) return 1;
    if (raw > MaxWidth) return MaxWidth;
    return int'(raw);
  endfunction

  function automatic int active_height(input logic [HeightBits-1:0] raw);
    if (raw == 0) return 1;
    return int'(raw);
  endfunction

  function automatic logic [7:0] error_share(input int err, input logic [2:0] weight);
    int prod;
    prod = (err * int'(weight)) / 16;
    return prod[7:0];
  endfunction

  // Dithers one pixel and advances the raster position.
  function automatic out_t dither_pixel(input logic [7:0] pix);
    int         w;
    int         h;
    int         col;
    int         err;
    logic [7:0] above;
    logic [7:0] work;
    out_t       res;
    w   = active_width(cfg_width);
    h   = active_height(cfg_height);
    col = (pos_col >= w) ? w - 1 : pos_col;
    res.end_of_row   = (col + 1 >= w);
    res.end_of_frame = res.end_of_row && (pos_row + 1 >= h);
    above = (pos_row > 0) ? row_errors[col] : 8'd0;
    work  = pix + above + right_share;
    res.level = (work > 8'd127);
    err = int'(work) - (res.level ? int'(WhiteLevel) : 0);
    if (col > 0) begin
      row_errors[col-1] = below_left_sum + error_share(err, WeightBelowLeft);
      if (col > written_span) written_span = col;
    end
    below_left_sum = below_sum + error_share(err, WeightBelow);
    below_sum      = error_share(err, WeightBelowRight);
    right_share    = error_share(err, WeightRight);
    if (res.end_of_row) begin
      row_errors[col] = below_left_sum;
      if (col + 1 > written_span) written_span = col + 1;
      below_left_sum = '0;
      below_sum      = '0;
      right_share    = '0;
      pos_col        = 0;
      if (res.end_of_frame) begin
        pos_row = 0;
        frames_done++;
      end else begin
        pos_row = (pos_row + 1) & 32'hFFFF;
      end
    end else begin
      pos_col = col + 1;
    end
    return res;
  endfunction

  function automatic logic [7:0] gray_sample(input logic [7:0] flat);
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd127 + 8'($urandom_range(0, 1));
      3, 4:    return flat;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one pixel and waits until the block takes it. Valid drops only
  // between bursts.
  task automatic send_pixel(input logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      if (steady) begin
        gap        = 0;
        burst_left = 64;
      end else begin
        gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                 : $urandom_range(0, 2);
        burst_left = $urandom_range(1, 24);
      end
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_px.push_back(dither_pixel(pix));
    pixels_sent++;
  endtask

  // Lets every expected word come out, plus the deferred row-end RAM write.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [DataBits-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegWidth) cfg_width = value[WidthBits-1:0];
    else cfg_height = value[HeightBits-1:0];
    reg_writes++;
  endtask

  task automatic check_reg(input logic idx, input logic [DataBits-1:0] want);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      mismatch_count++;
      $display("%0t: register %0d read: expected %h, actual %h", $time, idx, want, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: its own stall pattern, a long hold-off on request, and full
  // speed while the sender runs steady.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      period_phase++;
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 9) < 3);
        default: m_axis_tready <= ((period_phase % 7) < 4);
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_checked++;
      if (expected_px.size() == 0) begin
        mismatch_count++;
        $display("%0t: word: expected none, actual tdata %h tlast %b tuser %b",
                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = expected_px.pop_front();
        if (m_axis_tdata !== {7'b0, want.level}) begin
          mismatch_count++;
          $display("%0t: level: expected %h, actual %h",
                   $time, {7'b0, want.level}, m_axis_tdata);
        end
        if (m_axis_tlast !== want.end_of_row) begin
          mismatch_count++;
          $display("%0t: end_of_row: expected %b, actual %b",
                   $time, want.end_of_row, m_axis_tlast);
        end
        if (m_axis_tuser !== want.end_of_frame) begin
          mismatch_count++;
          $display("%0t: end_of_frame: expected %b, actual %b",
                   $time, want.end_of_frame, m_axis_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d words outstanding", $time, expected_px.size());
      $display("error_diffusion_dither_1bit verification failed");
      $finish;
    end
  end

  task automatic test_register_access();
    check_reg(RegWidth, DataBits'(WidthReset));
    check_reg(RegHeight, DataBits'(HeightReset));
    write_reg(RegWidth, 32'hFFFF_FFFF);
    check_reg(RegWidth, 32'h0000_0FFF);
    write_reg(RegHeight, 32'hFFFF_FFFF);
    check_reg(RegHeight, 32'h0000_FFFF);
    write_reg(RegWidth, 32'h0);
    check_reg(RegWidth, 32'h0);
    write_reg(RegHeight, 32'h0);
    check_reg(RegHeight, 32'h0);
  endtask

  // Zero width and zero height both act as one, so every pixel ends a frame.
  task automatic test_zero_sizes();
    send_pixel(8'd0);
    send_pixel(8'd255);
    wait_idle();
  endtask

  // A black 127 pushes a large right share onto a 255, which wraps.
  task automatic test_pixel_extremes();
    logic [7:0] frame_a [6] = '{8'd127, 8'd255, 8'd0, 8'd255, 8'd127, 8'd255};
    logic [7:0] frame_b [6] = '{8'd128, 8'd0, 8'd128, 8'd1, 8'd254, 8'd0};
    write_reg(RegWidth, 32'd3);
    write_reg(RegHeight, 32'd2);
    foreach (frame_a[i]) send_pixel(frame_a[i]);
    foreach (frame_b[i]) send_pixel(frame_b[i]);
    wait_idle();
  endtask

  // Narrowing while past the new last column ends the row at once; lowering
  // the height below the current row ends the frame at the next row end.
  task automatic test_mid_frame_resize();
    write_reg(RegWidth, 32'd4);
    write_reg(RegHeight, 32'd65535);
    repeat (6) send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(RegWidth, 32'd2);
    send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
    write_reg(RegHeight, 32'd2);
    repeat (2) send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  // A width above the store size is clamped to it, so a long row runs on
  // without an early row end.
  task automatic test_full_width();
    logic [7:0] flat;
    write_reg(RegWidth, 32'h0000_0FFF);
    write_reg(RegHeight, 32'd1);
    flat   = 8'($urandom_range(0, 255));
    steady = 1'b1;
    repeat (WidePixels) send_pixel(gray_sample(flat));
    steady = 1'b0;
    repeat (WidePixels) send_pixel(gray_sample(flat));
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    write_reg(RegWidth, 32'd6);
    write_reg(RegHeight, 32'd4);
    hold_left = 300;
    repeat (48) send_pixel(8'($urandom_range(0, 255)));
    wait_idle();
  endtask

  task automatic test_random_frames();
    int         goal;
    int         phase;
    int         wv;
    int         hv;
    int         ew;
    int         eh;
    int         count;
    logic [7:0] flat;
    logic [31:0] junk;
    goal  = pixels_sent + RandomPixels;
    phase = 0;
    while (pixels_sent < goal) begin
      wait_idle();
      steady = (phase % 6 == 5);
      case ($urandom_range(0, 19))
        0:       wv = 0;
        1:       wv = $urandom_range(150, 400);
        2, 3:    wv = $urandom_range(13, 64);
        default: wv = $urandom_range(1, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       hv = 0;
        1:       hv = 65535;
        2:       hv = $urandom_range(7, 20);
        default: hv = $urandom_range(1, 6);
      endcase
      // Widening inside a lower row would read store entries never written.
      if (pos_row != 0 && active_width(wv[11:0]) > written_span) wv = written_span;
      junk = $urandom();
      write_reg(RegWidth, {junk[31:12], wv[11:0]});
      write_reg(RegHeight, {junk[31:16], hv[15:0]});
      ew = active_width(wv[11:0]);
      eh = active_height(hv[15:0]);
      if (pos_col == 0 && pos_row == 0 && ew * eh <= 300 && $urandom_range(0, 3) != 0)
        count = ew * eh * $urandom_range(1, 2);
      else
        count = $urandom_range(1, (3 * ew < 300) ? 3 * ew : 300);
      flat = 8'($urandom_range(0, 255));
      repeat (count) send_pixel(gray_sample(flat));
      phase++;
    end
    steady = 1'b0;
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_zero_sizes();
    test_pixel_extremes();
    test_mid_frame_resize();
    test_full_width();
    test_output_backpressure();
    test_random_frames();
    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d pixels (%0d whole frames) over %0d register writes, incl. zero,",
             pixels_sent, frames_done, reg_writes);
    $display("oversized and mid-frame sizes; checked %0d words, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0 && expected_px.size() == 0) begin
      $display("error_diffusion_dither_1bit verification clean");
    end else begin
      $display("error_diffusion_dither_1bit verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/edd_pkg.sv
sv/edd_ram.sv
sv/edd_core.sv
sv/edd_out_buf.sv
sv/error_diffusion_dither_1bit.sv
sv/edd_checker.sv
verif/error_diffusion_dither_1bit_tb.sv
